@@ rtl/lav_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the look-at view matrix block.
// No dependencies; lav_offs, the top level and the bench files import it.
package lav_pkg;

    // Row codes on the result channel
    localparam logic [1:0] ROW_U = 2'd0;
    localparam logic [1:0] ROW_V = 2'd1;
    localparam logic [1:0] ROW_N = 2'd2;

    // Saturation limits of a Q16.16 word
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] upper_x;
        logic signed [31:0] upper_y;
        logic signed [31:0] upper_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] row_x;
        logic signed [31:0] row_y;
        logic signed [31:0] row_z;
        logic signed [31:0] row_offset;
        logic [1:0]         row_index;
        logic               last;
        logic               degenerate;
    } t_out_item;

    // One finished matrix row before serialization
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] offset;
    } t_row_data;

endpackage

@@ rtl/lav_stream_if.sv @@
`timescale 1ns / 1ps
// Valid/ready stream interface used for the item and row channels.
// Payload type is a parameter; no other dependencies.
interface lav_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lav_norm.sv @@
`timescale 1ns / 1ps
// Pipelined vector normalizer: abs, shift search, sum of squares,
// bit-per-stage square root and restoring division. No dependencies.
module lav_norm #(
    parameter int IN_W      = 33,
    parameter int FRAC_BITS = 16,
    parameter int SB_W      = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [2:0][IN_W-1:0]        i_vec,
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_valid,
    output logic [2:0][FRAC_BITS+1:0]   o_vec,
    output logic                        o_zero,
    output logic [SB_W-1:0]             o_sb
);
    localparam int SW   = (IN_W < 32) ? 32 : IN_W;
    localparam int SK   = $clog2(SW);
    localparam int SQ_N = 32;
    localparam int DQ   = FRAC_BITS + 1;
    localparam int NW   = 32 + FRAC_BITS;
    localparam int CW   = FRAC_BITS + 2;
    localparam int LAT  = 38 + SK + DQ;
    localparam int DLW  = SB_W + 4;

    // side line: valid, sideband, signs and zero flag
    logic [LAT-1:0]  r_vl;
    logic [DLW-1:0]  r_dl [LAT];
    logic [2:0]      in_neg;
    logic            in_zero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_neg[i] = i_vec[i][IN_W-1];
        end
        in_zero = (i_vec == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl <= '0;
        end else if (i_en) begin
            r_vl <= {r_vl[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl[0] <= {i_sb, in_neg, in_zero};
            for (int s = 1; s < LAT; s++) begin
                r_dl[s] <= r_dl[s-1];
            end
        end
    end

    // magnitudes
    logic [SW-1:0] n_a_mag [3];
    logic [SW-1:0] r_a_mag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_mag[i] = SW'(i_vec[i][IN_W-1] ? (~i_vec[i] + 1'b1) : i_vec[i]);
        end
    end

    // largest magnitude, then shift search moving its top bit to the msb
    logic [SW-1:0] ab_max;
    logic [SW-1:0] n_max;
    logic [SW-1:0] r_sh [SK+1][4];
    logic [SK-1:0] sh_top_zero;

    always_comb begin
        ab_max = (r_a_mag[0] > r_a_mag[1]) ? r_a_mag[0] : r_a_mag[1];
        n_max  = (ab_max > r_a_mag[2]) ? ab_max : r_a_mag[2];
        for (int k = 0; k < SK; k++) begin
            sh_top_zero[k] = (r_sh[k][3] >> (SW - (1 << (SK - 1 - k)))) == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_mag[i] <= n_a_mag[i];
                r_sh[0][i] <= r_a_mag[i];
            end
            r_sh[0][3] <= n_max;
            for (int k = 0; k < SK; k++) begin
                for (int i = 0; i < 4; i++) begin
                    if (sh_top_zero[k]) begin
                        r_sh[k+1][i] <= r_sh[k][i] << (1 << (SK - 1 - k));
                    end else begin
                        r_sh[k+1][i] <= r_sh[k][i];
                    end
                end
            end
        end
    end

    // squares and their sum
    logic [30:0] m31  [3];
    logic [61:0] r_p  [3];
    logic [30:0] r_pm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m31[i] = r_sh[SK][i][SW-1 -: 31];
        end
    end

    // square root, one result bit per stage
    logic [63:0] r_sn [SQ_N+1];
    logic [63:0] r_sr [SQ_N+1];
    logic [30:0] r_mc [SQ_N+1][3];
    logic [63:0] n_sn [SQ_N];
    logic [63:0] n_sr [SQ_N];
    logic [63:0] sq_bit [SQ_N];
    logic [63:0] sq_try [SQ_N];

    always_comb begin
        for (int j = 0; j < SQ_N; j++) begin
            sq_bit[j] = 64'd1 << (62 - 2 * j);
            sq_try[j] = r_sr[j] + sq_bit[j];
            if (r_sn[j] >= sq_try[j]) begin
                n_sn[j] = r_sn[j] - sq_try[j];
                n_sr[j] = (r_sr[j] >> 1) + sq_bit[j];
            end else begin
                n_sn[j] = r_sn[j];
                n_sr[j] = r_sr[j] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i]     <= m31[i] * m31[i];
                r_pm[i]    <= m31[i];
                r_mc[0][i] <= r_pm[i];
            end
            r_sn[0] <= 64'(r_p[0]) + 64'(r_p[1]) + 64'(r_p[2]);
            r_sr[0] <= '0;
            for (int j = 0; j < SQ_N; j++) begin
                r_sn[j+1] <= n_sn[j];
                r_sr[j+1] <= n_sr[j];
                for (int i = 0; i < 3; i++) begin
                    r_mc[j+1][i] <= r_mc[j][i];
                end
            end
        end
    end

    // rounded division by the length, one quotient bit per stage
    logic [31:0]   dv_len;
    logic [NW-1:0] dv_num [3];
    logic [31:0]   r_len  [DQ+1];
    logic [31:0]   r_rem  [DQ+1][3];
    logic [DQ-1:0] r_low  [DQ+1][3];
    logic [DQ-1:0] r_q    [DQ+1][3];
    logic [32:0]   dv_t   [DQ][3];
    logic          dv_ge  [DQ][3];

    always_comb begin
        dv_len = r_sr[SQ_N][31:0];
        for (int i = 0; i < 3; i++) begin
            dv_num[i] = (NW'(r_mc[SQ_N][i]) << FRAC_BITS) + NW'(dv_len >> 1);
        end
        for (int j = 0; j < DQ; j++) begin
            for (int i = 0; i < 3; i++) begin
                dv_t[j][i]  = {r_rem[j][i], r_low[j][i][DQ-1]};
                dv_ge[j][i] = dv_t[j][i] >= {1'b0, r_len[j]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[0] <= dv_len;
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= 32'(dv_num[i] >> DQ);
                r_low[0][i] <= dv_num[i][DQ-1:0];
                r_q[0][i]   <= '0;
            end
            for (int j = 0; j < DQ; j++) begin
                r_len[j+1] <= r_len[j];
                for (int i = 0; i < 3; i++) begin
                    r_rem[j+1][i] <= dv_ge[j][i] ? 32'(dv_t[j][i] - {1'b0, r_len[j]})
                                                 : dv_t[j][i][31:0];
                    r_low[j+1][i] <= r_low[j][i] << 1;
                    r_q[j+1][i]   <= (r_q[j][i] << 1) | DQ'(dv_ge[j][i]);
                end
            end
        end
    end

    // sign and zero vector
    logic [2:0]          fin_neg;
    logic                fin_zero;
    logic [2:0][CW-1:0]  n_out;
    logic [2:0][CW-1:0]  r_out;

    always_comb begin
        fin_neg  = r_dl[LAT-2][3:1];
        fin_zero = r_dl[LAT-2][0];
        for (int i = 0; i < 3; i++) begin
            if (fin_zero) begin
                n_out[i] = '0;
            end else if (fin_neg[i]) begin
                n_out[i] = ~{1'b0, r_q[DQ][i]} + 1'b1;
            end else begin
                n_out[i] = {1'b0, r_q[DQ][i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vl[LAT-1];
    assign o_vec   = r_out;
    assign o_zero  = r_dl[LAT-1][0];
    assign o_sb    = r_dl[LAT-1][DLW-1:4];
endmodule

@@ rtl/lav_cross.sv @@
`timescale 1ns / 1ps
// Two-stage cross product of signed vectors: products, then differences.
// No dependencies.
module lav_cross #(
    parameter int A_W  = 18,
    parameter int SB_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0][A_W-1:0]    i_a,
    input  logic [2:0][A_W-1:0]    i_b,
    input  logic [SB_W-1:0]        i_sb,
    output logic                   o_valid,
    output logic [2:0][2*A_W:0]    o_c,
    output logic [SB_W-1:0]        o_sb
);
    localparam int PW = 2 * A_W;
    localparam int XW = 2 * A_W + 1;

    logic [1:0]             r_v;
    logic [SB_W-1:0]        r_sb [2];
    logic signed [PW-1:0]   r_p  [6];
    logic [2:0][XW-1:0]     r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    // products, then the three differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= $signed(i_a[1]) * $signed(i_b[2]);
            r_p[1] <= $signed(i_a[2]) * $signed(i_b[1]);
            r_p[2] <= $signed(i_a[2]) * $signed(i_b[0]);
            r_p[3] <= $signed(i_a[0]) * $signed(i_b[2]);
            r_p[4] <= $signed(i_a[0]) * $signed(i_b[1]);
            r_p[5] <= $signed(i_a[1]) * $signed(i_b[0]);
            r_c[0] <= XW'(r_p[0]) - XW'(r_p[1]);
            r_c[1] <= XW'(r_p[2]) - XW'(r_p[3]);
            r_c[2] <= XW'(r_p[4]) - XW'(r_p[5]);
            r_sb[0] <= i_sb;
            r_sb[1] <= r_sb[0];
        end
    end

    assign o_valid = r_v[1];
    assign o_c     = r_c;
    assign o_sb    = r_sb[1];
endmodule

@@ rtl/lav_offs.sv @@
`timescale 1ns / 1ps
// Row offsets -dot(axis, eye) with rounding and saturation, three stages.
// Depends on lav_pkg.
module lav_offs
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_ok,
    input  logic [2:0][2:0][FRAC_BITS+1:0]      i_axes,
    input  logic [2:0][31:0]                    i_eye,
    output logic                                o_valid,
    output t_row_data [2:0]                     o_rows,
    output logic                                o_degen
);
    localparam int CW = FRAC_BITS + 2;
    localparam int PW = CW + 32;
    localparam int TW = PW + 2;

    logic [2:0]                 r_v;
    logic [1:0]                 r_ok;
    logic [2:0][2:0][CW-1:0]    r_ax [2];
    logic signed [PW-1:0]       r_p  [3][3];
    logic signed [TW-1:0]       r_t  [3];
    logic signed [TW-1:0]       fl   [3];
    logic signed [TW:0]         ng   [3];
    logic signed [31:0]         sat  [3];
    t_row_data [2:0]            n_rows;
    t_row_data [2:0]            r_rows;
    logic                       r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // round to nearest, negate, clamp to 32 bits
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            fl[r] = r_t[r] >>> FRAC_BITS;
            ng[r] = -((TW+1)'(fl[r]));
            if ((&ng[r][TW:31]) || !(|ng[r][TW:31])) begin
                sat[r] = ng[r][31:0];
            end else begin
                sat[r] = ng[r][TW] ? Q_MIN : Q_MAX;
            end
            if (r_ok[1]) begin
                n_rows[r].x      = 32'($signed(r_ax[1][r][0]));
                n_rows[r].y      = 32'($signed(r_ax[1][r][1]));
                n_rows[r].z      = 32'($signed(r_ax[1][r][2]));
                n_rows[r].offset = sat[r];
            end else begin
                n_rows[r] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[r][c] <= $signed(i_axes[r][c]) * $signed(i_eye[c]);
                end
                r_t[r] <= TW'(r_p[r][0]) + TW'(r_p[r][1]) + TW'(r_p[r][2])
                          + TW'(64'd1 << (FRAC_BITS - 1));
            end
            r_ax[0] <= i_axes;
            r_ax[1] <= r_ax[0];
            r_ok    <= {r_ok[0], i_ok};
            r_rows  <= n_rows;
            r_degen <= !r_ok[1];
        end
    end

    assign o_valid = r_v[2];
    assign o_rows  = r_rows;
    assign o_degen = r_degen;
endmodule

@@ rtl/look_at_view_matrix.sv @@
`timescale 1ns / 1ps
// Look-at view matrix top level: differences, normalizers, cross products,
// offsets and the row serializer. Depends on lav_pkg and lav_stream_if.
//
// Usage
//   i_item takes one camera item (eye, target, up point, signed Q.F) on a
//   valid/ready handshake. o_row returns three rows per item, U, V then N,
//   each with its axis, its offset -dot(axis, eye), row_index, last on the
//   N row, and degenerate when a normalized vector had zero length (rows
//   are then zero).
//   The delay from accept to the first row is set mainly by the three
//   chained normalizers, each with a 32-stage square root and a
//   FRAC_BITS+1 stage divider. The three-row serializer at the output
//   holds the pipeline while it returns an item's rows before the last;
//   the pipeline itself takes an item in every cycle it moves.
//   The whole pipeline advances on one enable: while o_row is stalled with
//   rows left, nothing moves and nothing is lost or repeated.
//   Reset clears every valid bit and the row counter; data needs no reset.
module look_at_view_matrix
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lav_stream_if.sink           i_item,
    lav_stream_if.source         o_row
);
    localparam int CW  = FRAC_BITS + 2;
    localparam int XW  = 2 * CW + 1;
    localparam int SB1 = 3 * CW + 98;
    localparam int SB2 = SB1 + 1 + 3 * CW;

    logic en;

    // input differences
    logic               r_d_v;
    logic [2:0][32:0]   r_d_nd;
    logic [2:0][32:0]   r_d_wd;
    logic [2:0][31:0]   r_d_eye;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_nd[0] <= 33'(i_item.data.eye_x) - 33'(i_item.data.target_x);
            r_d_nd[1] <= 33'(i_item.data.eye_y) - 33'(i_item.data.target_y);
            r_d_nd[2] <= 33'(i_item.data.eye_z) - 33'(i_item.data.target_z);
            r_d_wd[0] <= 33'(i_item.data.upper_x) - 33'(i_item.data.eye_x);
            r_d_wd[1] <= 33'(i_item.data.upper_y) - 33'(i_item.data.eye_y);
            r_d_wd[2] <= 33'(i_item.data.upper_z) - 33'(i_item.data.eye_z);
            r_d_eye   <= {i_item.data.eye_z, i_item.data.eye_y, i_item.data.eye_x};
        end
    end

    // N and W normalizers; the eye point rides along split across both
    logic               nn_v, nw_v, nn_z, nw_z;
    logic [2:0][CW-1:0] nn_vec, nw_vec;
    logic [63:0]        nn_sb;
    logic [31:0]        nw_sb;

    lav_norm #(.IN_W(33), .FRAC_BITS(FRAC_BITS), .SB_W(64)) u_norm_n (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_d_v),
        .i_vec(r_d_nd), .i_sb({r_d_eye[1], r_d_eye[0]}),
        .o_valid(nn_v), .o_vec(nn_vec), .o_zero(nn_z), .o_sb(nn_sb)
    );

    lav_norm #(.IN_W(33), .FRAC_BITS(FRAC_BITS), .SB_W(32)) u_norm_w (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_d_v),
        .i_vec(r_d_wd), .i_sb(r_d_eye[2]),
        .o_valid(nw_v), .o_vec(nw_vec), .o_zero(nw_z), .o_sb(nw_sb)
    );

    // N x W, then U
    logic               c1_v;
    logic [2:0][XW-1:0] c1_vec;
    logic [SB1-1:0]     c1_sb;

    lav_cross #(.A_W(CW), .SB_W(SB1)) u_cross_nw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(nn_v && nw_v),
        .i_a(nn_vec), .i_b(nw_vec), .i_sb({nw_sb, nn_sb, nn_z, nw_z, nn_vec}),
        .o_valid(c1_v), .o_c(c1_vec), .o_sb(c1_sb)
    );

    logic               nu_v, nu_z;
    logic [2:0][CW-1:0] nu_vec;
    logic [SB1-1:0]     nu_sb;

    lav_norm #(.IN_W(XW), .FRAC_BITS(FRAC_BITS), .SB_W(SB1)) u_norm_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(c1_v),
        .i_vec(c1_vec), .i_sb(c1_sb),
        .o_valid(nu_v), .o_vec(nu_vec), .o_zero(nu_z), .o_sb(nu_sb)
    );

    // U x N, then V
    logic               c2_v;
    logic [2:0][XW-1:0] c2_vec;
    logic [SB2-1:0]     c2_sb;

    lav_cross #(.A_W(CW), .SB_W(SB2)) u_cross_un (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(nu_v),
        .i_a(nu_vec), .i_b(nu_sb[3*CW-1:0]), .i_sb({nu_sb, nu_z, nu_vec}),
        .o_valid(c2_v), .o_c(c2_vec), .o_sb(c2_sb)
    );

    logic               nv_v, nv_z;
    logic [2:0][CW-1:0] nv_vec;
    logic [SB2-1:0]     nv_sb;

    lav_norm #(.IN_W(XW), .FRAC_BITS(FRAC_BITS), .SB_W(SB2)) u_norm_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(c2_v),
        .i_vec(c2_vec), .i_sb(c2_sb),
        .o_valid(nv_v), .o_vec(nv_vec), .o_zero(nv_z), .o_sb(nv_sb)
    );

    // unpack sideband: u, zu, n, zw, zn, eye
    logic [2:0][CW-1:0] fin_u, fin_n;
    logic               fin_ok;
    logic [2:0][31:0]   fin_eye;

    always_comb begin
        fin_u   = nv_sb[3*CW-1:0];
        fin_n   = nv_sb[3*CW+1 +: 3*CW];
        fin_eye = nv_sb[6*CW+3 +: 96];
        fin_ok  = !(nv_z || nv_sb[3*CW] || nv_sb[6*CW+1] || nv_sb[6*CW+2]);
    end

    logic               of_v, of_degen;
    t_row_data [2:0]    of_rows;

    lav_offs #(.FRAC_BITS(FRAC_BITS)) u_offs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(nv_v),
        .i_ok(fin_ok), .i_axes({fin_n, nv_vec, fin_u}), .i_eye(fin_eye),
        .o_valid(of_v), .o_rows(of_rows), .o_degen(of_degen)
    );

    // row serializer; the pipeline moves when it is empty or its last row is taken
    logic               r_hv;
    logic [1:0]         r_idx;
    t_row_data [2:0]    r_hold;
    logic               r_hdeg;

    assign en = !r_hv || (o_row.ready && (r_idx == ROW_N));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_idx <= ROW_U;
        end else begin
            if (r_hv && o_row.ready) begin
                r_idx <= (r_idx == ROW_N) ? ROW_U : r_idx + 2'd1;
            end
            if (en) begin
                r_hv <= of_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hold <= of_rows;
            r_hdeg <= of_degen;
        end
    end

    assign i_item.ready = en;
    assign o_row.valid  = r_hv;

    always_comb begin
        o_row.data.row_x      = r_hold[r_idx].x;
        o_row.data.row_y      = r_hold[r_idx].y;
        o_row.data.row_z      = r_hold[r_idx].z;
        o_row.data.row_offset = r_hold[r_idx].offset;
        o_row.data.row_index  = r_idx;
        o_row.data.last       = (r_idx == ROW_N);
        o_row.data.degenerate = r_hdeg;
    end
endmodule

@@ bench/lav_checker.sv @@
`timescale 1ns / 1ps
// Row checker for the look-at view matrix block: watches both channels,
// predicts the three rows of each accepted item and compares them.
// Depends on lav_pkg.
module lav_checker
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    t_out_item rows_due[$];

    // Integer square root, bit by bit
    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scale so the largest magnitude sits in [2^30, 2^31), then divide by length
    function automatic bit unit_vec(input longint a[3], output longint r[3]);
        logic [63:0] mag[3];
        logic [63:0] m, sum, len, q;
        bit neg[3];
        int rs, ls;
        m = 0; sum = 0; rs = 0; ls = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = a[i] < 0;
            mag[i] = neg[i] ? 64'd0 - 64'(a[i]) : 64'(a[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            for (int i = 0; i < 3; i++) r[i] = 0;
            return 0;
        end
        while (m >= (64'd1 << 31)) begin m = m >> 1; rs++; end
        while (m < (64'd1 << 30)) begin m = m << 1; ls++; end
        for (int i = 0; i < 3; i++) begin
            mag[i] = (mag[i] >> rs) << ls;
            sum    = sum + mag[i] * mag[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
            q    = ((mag[i] << FRAC_BITS) + (len >> 1)) / len;
            r[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // -round(dot(axis, eye)), saturated to 32 bits
    function automatic logic signed [31:0] row_offset_of(input longint ax[3],
                                                          input longint e[3]);
        longint d, t, f;
        d = ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2];
        t = d + (64'sd1 <<< (FRAC_BITS - 1));
        f = t >>> FRAC_BITS;
        f = -f;
        if (f > 64'sd2147483647) return Q_MAX;
        if (f < -64'sd2147483648) return Q_MIN;
        return 32'(f);
    endfunction

    task automatic predict_rows(input t_in_item it);
        longint eye[3], nd[3], wd[3], n[3], w[3], c[3], u[3], v[3], ax[3];
        bit ok;
        t_out_item r;
        eye = '{longint'(it.eye_x), longint'(it.eye_y), longint'(it.eye_z)};
        nd  = '{eye[0] - it.target_x, eye[1] - it.target_y, eye[2] - it.target_z};
        wd  = '{it.upper_x - eye[0], it.upper_y - eye[1], it.upper_z - eye[2]};
        ok  = unit_vec(nd, n);
        ok  = unit_vec(wd, w) && ok;
        cross3(n, w, c);
        ok  = unit_vec(c, u) && ok;
        cross3(u, n, c);
        ok  = unit_vec(c, v) && ok;
        for (int k = 0; k < 3; k++) begin
            case (k)
                0:       ax = u;
                1:       ax = v;
                default: ax = n;
            endcase
            r  = '0;
            if (ok) begin
                r.row_x      = 32'(ax[0]);
                r.row_y      = 32'(ax[1]);
                r.row_z      = 32'(ax[2]);
                r.row_offset = row_offset_of(ax, eye);
            end
            r.row_index  = (k == 0) ? ROW_U : (k == 1) ? ROW_V : ROW_N;
            r.last       = (k == 2);
            r.degenerate = !ok;
            rows_due.push_back(r);
        end
    endtask

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = rows_due.size();

    // Sample both channels at the edge; the driver updates after it
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) predict_rows(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (rows_due.size() == 0) begin
                    report("row with no item pending");
                end else begin
                    want = rows_due.pop_front();
                    if (i_out_data.row_x !== want.row_x)
                        report($sformatf("row_x %h want %h", i_out_data.row_x, want.row_x));
                    if (i_out_data.row_y !== want.row_y)
                        report($sformatf("row_y %h want %h", i_out_data.row_y, want.row_y));
                    if (i_out_data.row_z !== want.row_z)
                        report($sformatf("row_z %h want %h", i_out_data.row_z, want.row_z));
                    if (i_out_data.row_offset !== want.row_offset)
                        report($sformatf("offset %h want %h",
                                         i_out_data.row_offset, want.row_offset));
                    if (i_out_data.row_index !== want.row_index)
                        report($sformatf("index %0d want %0d",
                                         i_out_data.row_index, want.row_index));
                    if (i_out_data.last !== want.last)
                        report($sformatf("last %b want %b", i_out_data.last, want.last));
                    if (i_out_data.degenerate !== want.degenerate)
                        report($sformatf("degenerate %b want %b",
                                         i_out_data.degenerate, want.degenerate));
                end
            end
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the look-at view matrix testbench: clock, reset, camera stimulus
// and verdict. Depends on lav_pkg, lav_stream_if, lav_checker and the block.
module tb_top
    import lav_pkg::*;
;

    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = 3 * (FRAC_BITS + 45) + 8;
    localparam int LIMIT     = 400000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    int   send_idle;   // percent of cycles the sender holds off
    int   recv_stall;  // percent of cycles the receiver stalls

    lav_stream_if #(.T(t_in_item))  item_ch ();
    lav_stream_if #(.T(t_out_item)) row_ch ();

    look_at_view_matrix #(.FRAC_BITS(FRAC_BITS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_row   (row_ch.source)
    );

    lav_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (item_ch.valid),
        .i_in_ready   (item_ch.ready),
        .i_in_data    (item_ch.data),
        .i_out_valid  (row_ch.valid),
        .i_out_ready  (row_ch.ready),
        .i_out_data   (row_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 0;
    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // Timeout watch
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver stalls at the set rate
    always @(posedge i_clk) begin
        row_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'($urandom_range(65535)) - 32'sd32768;
            3: return 32'($urandom_range(2000000)) - 32'sd1000000;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item; valid stays up until accepted
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_cam(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
        t_in_item it;
        it = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
        send_item(it);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_in_item it;
        int one;
        one = 1 << FRAC_BITS;
        send_idle  = 0;
        recv_stall = 0;
        i_rst_n       = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        row_ch.ready  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cameras
        send_cam(0, 0, 5 * one, 0, 0, 0, 0, one, 5 * one);
        send_cam(one, 2 * one, 3 * one, -one, 0, one, one, 3 * one, 3 * one);
        send_cam(one, one, one, one, one, one, 0, one, 0);         // eye on target
        send_cam(one, one, one, 0, 0, 0, one, one, one);           // up point on eye
        send_cam(0, 0, one, 0, 0, 0, 0, 0, 2 * one);               // N parallel to W
        send_cam(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cam(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN);
        send_cam(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX);
        send_cam(Q_MAX, 0, Q_MIN, 0, Q_MAX, 0, Q_MIN, Q_MIN, Q_MAX);  // offset saturation
        send_cam(-1, -1, -1, 0, 0, 0, 1, 0, -1);                   // tiny vectors
        send_cam(Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN, -1, 0, 0, Q_MAX);
        send_cam(100 * one, -50 * one, 7, 0, 0, 0, 3, one, -9);
        send_cam(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        wait_drained();  // sender holds off until all rows are back

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? 86 : 0;
            recv_stall = (ph == 2 || ph == 3) ? 86 : 0;
            if (ph == 3) begin
                send_idle  = 7;
                recv_stall = 7;
            end
            for (int n = 0; n < 42; n++) begin
                it = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word(), rand_word()};
                if ($urandom_range(15) == 0) it.target_x = it.eye_x;
                if ($urandom_range(15) == 0) begin
                    it.target_x = it.eye_x;
                    it.target_y = it.eye_y;
                    it.target_z = it.eye_z;
                end
                if ($urandom_range(15) == 0) begin
                    it.upper_x = it.eye_x;
                    it.upper_y = it.eye_y;
                    it.upper_z = it.eye_z;
                end
                send_item(it);
            end
        end
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
